[sv/mt64_pkg.sv]
// ----------------------------------------------------------------------------
// MT19937-64 package
// Constants and shared types for the 64-bit Mersenne Twister generator.
// ----------------------------------------------------------------------------
package mt64_pkg;

  localparam int unsigned TableWords = 312;
  localparam int unsigned MiddleOffset = 156;
  localparam int unsigned IdxW = 9;

  localparam logic [63:0] InitMult    = 64'd6364136223846793005;
  localparam logic [63:0] TwistMatrix = 64'hB5026F5AA96619E9;
  localparam logic [63:0] UpperMask   = 64'hFFFFFFFF80000000;
  localparam logic [63:0] LowerMask   = 64'h000000007FFFFFFF;
  localparam logic [63:0] DefaultSeed = 64'd5489;

  localparam logic [1:0] OpRestart = 2'd0;
  localparam logic [1:0] OpRaw     = 2'd1;
  localparam logic [1:0] OpRange   = 2'd2;
  localparam logic [1:0] OpNone    = 2'd3;

  // Handshake between the sequencer and the modulo unit.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] remainder;
  } mod_rsp_t;

  function automatic logic [63:0] temper(input logic [63:0] w);
    logic [63:0] x;
    x = w;
    x = x ^ ((x >> 29) & 64'h5555555555555555);
    x = x ^ ((x << 17) & 64'h71D67FFFEDA60000);
    x = x ^ ((x << 37) & 64'hFFF7EEE000000000);
    x = x ^ (x >> 43);
    return x;
  endfunction

endpackage

[sv/mt64_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mt64_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 312
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/mt64_mod.sv]
// ----------------------------------------------------------------------------
// MT64 modulo unit
// Restoring division, one quotient bit per cycle, giving the remainder.
// ----------------------------------------------------------------------------
module mt64_mod
  import mt64_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] num_q, num_d;
  logic [63:0] div_q, div_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    rem_d   = rem_q;
    num_d   = num_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, num_q[63]};
    trial   = shifted - {1'b0, div_q};
    if (req_i.start) begin
      rem_d  = '0;
      num_d  = req_i.dividend;
      div_d  = req_i.divisor;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[62:0], 1'b0};
      rem_d = trial[64] ? shifted[63:0] : trial[63:0];
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

[sv/mersenne_twister_64_generator.sv]
// ----------------------------------------------------------------------------
// MT19937-64 generator
// 64-bit Mersenne Twister with restart, raw draws and ranged draws.
// ----------------------------------------------------------------------------
// Items enter on the in channel (opcode, range bounds) under valid/ready and
// each yields exactly one item on the out channel (value, empty_range). The
// block works on one item at a time; the input is not ready while the out
// register holds an item that the receiver has not taken, so a stalled
// receiver holds off new items.
// The 312-word state lives in one synchronous RAM. A restart writes word 0
// at acceptance and then the other 311 words, each with three 32 by 32
// partial products and a write, before its result is emitted. A draw twists
// one word on demand: the twist of word k must have finished before word k
// is read, so a draw reads word k, k+1 and k+156 one after another through
// the single read port and writes back, then reads and tempers its word.
// A ranged draw adds a pass through a bit-serial remainder unit. An empty
// range or an unused opcode goes straight to the emit state. After reset
// the same seeding pass runs with the default seed, and the input is not
// ready until it ends. The seed register is written by cfg_we_i and used
// at the next restart.
// ----------------------------------------------------------------------------
module mersenne_twister_64_generator
  import mt64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] range_min_i,
  input  logic [63:0] range_max_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic        empty_range_o
);

  localparam logic [3:0] StSeedMul = 4'd0;
  localparam logic [3:0] StSeedWr  = 4'd1;
  localparam logic [3:0] StIdle    = 4'd2;
  localparam logic [3:0] StRdK     = 4'd3;
  localparam logic [3:0] StRdK1    = 4'd4;
  localparam logic [3:0] StRdM     = 4'd5;
  localparam logic [3:0] StTwist   = 4'd6;
  localparam logic [3:0] StRdOut   = 4'd7;
  localparam logic [3:0] StTemper  = 4'd8;
  localparam logic [3:0] StMod     = 4'd9;
  localparam logic [3:0] StEmit    = 4'd10;

  logic [3:0]      st_q, st_d;
  logic [63:0]     seed_q;
  logic [IdxW-1:0] idx_q, idx_d;     // next word to hand out
  logic [IdxW-1:0] tw_q, tw_d;       // words twisted in the current round
  logic [IdxW-1:0] k_q, k_d;         // seeding position
  logic [63:0]     prev_q, prev_d;   // last seeded word
  logic [63:0]     prod_q, prod_d;
  logic [1:0]      mph_q, mph_d;     // partial product step of the seed multiply
  logic [63:0]     seed_x;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;
  logic [63:0]     a_q, a_d, b_q, b_d;
  logic [63:0]     res_q, res_d;
  logic            flag_q, flag_d;
  logic [1:0]      op_q, op_d;
  logic [63:0]     min_q, min_d, span_q, span_d;
  logic            ovalid_q, ovalid_d;
  logic [63:0]     oval_q, oval_d;
  logic            oflag_q, oflag_d;
  logic            ram_we;
  logic [IdxW-1:0] ram_wa, ram_ra;
  logic [63:0]     ram_wd, ram_rd;
  logic [63:0]     y;
  logic [IdxW-1:0] tw_next, tw_mid;
  mod_req_t        mreq;
  mod_rsp_t        mrsp;

  mt64_ram #(.Width(64), .Depth(TableWords)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(ram_wd),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  mt64_mod u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  assign tw_next = (tw_q == IdxW'(TableWords - 1)) ? '0 : tw_q + 1'b1;
  assign tw_mid  = (tw_q >= IdxW'(TableWords - MiddleOffset))
                 ? tw_q - IdxW'(TableWords - MiddleOffset)
                 : tw_q + IdxW'(MiddleOffset);
  assign y = (a_q & UpperMask) | (b_q & LowerMask);

  // Only the low 64 bits of the seed product are kept, so three partial
  // products suffice: low by low, then the two cross terms shifted by 32.
  assign seed_x = prev_q ^ (prev_q >> 62);
  assign mul_a  = (mph_q == 2'd1) ? seed_x[63:32] : seed_x[31:0];
  assign mul_b  = (mph_q == 2'd2) ? InitMult[63:32] : InitMult[31:0];
  assign mul_p  = mul_a * mul_b;

  assign in_ready_o = (st_q == StIdle) && !(ovalid_q && !out_ready_i);

  always_comb begin
    st_d     = st_q;
    idx_d    = idx_q;
    tw_d     = tw_q;
    k_d      = k_q;
    prev_d   = prev_q;
    prod_d   = prod_q;
    mph_d    = mph_q;
    a_d      = a_q;
    b_d      = b_q;
    res_d    = res_q;
    flag_d   = flag_q;
    op_d     = op_q;
    min_d    = min_q;
    span_d   = span_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oval_d   = oval_q;
    oflag_d  = oflag_q;
    ram_we   = 1'b0;
    ram_wa   = k_q;
    ram_wd   = prev_q;
    ram_ra   = tw_q;
    mreq     = '{start: 1'b0, dividend: a_q, divisor: span_q};
    case (st_q)
      StSeedMul: begin
        // Word 0 holds the seed itself; writing it here covers the pass
        // after reset as well as a restart.
        if (k_q == IdxW'(1) && mph_q == 2'd0) begin
          ram_we = 1'b1;
          ram_wa = '0;
          ram_wd = prev_q;
        end
        if (mph_q == 2'd0) begin
          prod_d = mul_p;
        end else begin
          prod_d = prod_q + {mul_p[31:0], 32'd0};
        end
        if (mph_q == 2'd2) begin
          mph_d = 2'd0;
          st_d  = StSeedWr;
        end else begin
          mph_d = mph_q + 2'd1;
        end
      end
      StSeedWr: begin
        ram_we = 1'b1;
        ram_wa = k_q;
        ram_wd = prod_q + 64'(k_q);
        prev_d = prod_q + 64'(k_q);
        if (k_q == IdxW'(TableWords - 1)) begin
          st_d = (op_q == OpRestart) ? StEmit : StIdle;
        end else begin
          k_d  = k_q + 1'b1;
          st_d = StSeedMul;
        end
      end
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          op_d   = opcode_i;
          min_d  = range_min_i;
          span_d = range_max_i - range_min_i;
          flag_d = 1'b0;
          case (opcode_i)
            OpRestart: begin
              ram_we = 1'b1;
              ram_wa = '0;
              ram_wd = seed_q;
              prev_d = seed_q;
              res_d  = seed_q;
              k_d    = IdxW'(1);
              idx_d  = IdxW'(TableWords);
              tw_d   = '0;
              st_d   = StSeedMul;
            end
            OpRaw: begin
              st_d = (idx_q == tw_q && idx_q != IdxW'(TableWords) || idx_q == IdxW'(TableWords))
                   ? StRdK : StRdOut;
            end
            OpRange: begin
              if (range_min_i >= range_max_i) begin
                res_d  = '0;
                flag_d = 1'b1;
                st_d   = StEmit;
              end else begin
                st_d = (idx_q == tw_q || idx_q == IdxW'(TableWords)) ? StRdK : StRdOut;
              end
            end
            default: begin
              res_d = oval_q;
              st_d  = StEmit;
            end
          endcase
          if (opcode_i == OpRaw) begin
            st_d = (idx_q == tw_q || idx_q == IdxW'(TableWords)) ? StRdK : StRdOut;
          end
          if (idx_q == IdxW'(TableWords) && opcode_i != OpRestart) begin
            idx_d = '0;
          end
        end
      end
      StRdK: begin
        ram_ra = tw_q;
        st_d   = StRdK1;
      end
      StRdK1: begin
        ram_ra = tw_next;
        a_d    = ram_rd;
        st_d   = StRdM;
      end
      StRdM: begin
        ram_ra = tw_mid;
        b_d    = ram_rd;
        st_d   = StTwist;
      end
      StTwist: begin
        ram_we = 1'b1;
        ram_wa = tw_q;
        ram_wd = ram_rd ^ (y >> 1) ^ (y[0] ? TwistMatrix : 64'd0);
        tw_d   = tw_next;
        st_d   = StRdOut;
      end
      StRdOut: begin
        ram_ra = idx_q;
        st_d   = StTemper;
      end
      StTemper: begin
        res_d = temper(ram_rd);
        a_d   = temper(ram_rd);
        idx_d = idx_q + 1'b1;
        if (op_q == OpRange) begin
          st_d = StMod;
        end else begin
          st_d = StEmit;
        end
      end
      StMod: begin
        mreq.start = (a_q == res_q) && !flag_q;
        flag_d     = 1'b1;
        if (mrsp.done) begin
          res_d  = mrsp.remainder + min_q;
          flag_d = 1'b0;
          st_d   = StEmit;
        end
      end
      StEmit: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          oval_d   = res_q;
          oflag_d  = flag_q;
          st_d     = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StSeedMul;
      seed_q   <= DefaultSeed;
      idx_q    <= IdxW'(TableWords);
      tw_q     <= '0;
      k_q      <= IdxW'(1);
      prev_q   <= DefaultSeed;
      mph_q    <= 2'd0;
      op_q     <= OpRaw;
      flag_q   <= 1'b0;
      ovalid_q <= 1'b0;
      oval_q   <= '0;
      oflag_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      idx_q    <= idx_d;
      tw_q     <= tw_d;
      k_q      <= k_d;
      prev_q   <= prev_d;
      mph_q    <= mph_d;
      op_q     <= op_d;
      flag_q   <= flag_d;
      ovalid_q <= ovalid_d;
      oval_q   <= oval_d;
      oflag_q  <= oflag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    min_q  <= min_d;
    span_q <= span_d;
  end

  assign out_valid_o   = ovalid_q;
  assign value_o       = oval_q;
  assign empty_range_o = oflag_q;

endmodule
